FILE: hdl/baro_pkg.sv
// ----------------------------------------------------------------------------
// baro_pkg: shared types and constants for barometric compensation
// Request and result payloads, register indexes and the fixed constants of
// the integer compensation formula.
// ----------------------------------------------------------------------------
package baro_pkg;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [18:0] raw_pressure;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] temp_tenths_c;
    logic        [17:0] pressure_pa;
    logic               div_error;
  } result_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4,
    REG_OSS     = 3'd5
  } reg_idx_t;

  localparam logic [1:0]          OSS_RESET = 2'd1;
  localparam logic signed [28:0]  B6_OFFSET = 29'sd4000;
  localparam logic signed [28:0]  T_ROUND   = 29'sd8;
  localparam logic [31:0]         X3_BIAS   = 32'd32768;
  localparam logic [16:0]         B7_SCALE  = 17'd50000;
  localparam logic [11:0]         C_P2      = 12'd3038;
  localparam logic signed [13:0]  C_P1      = -14'sd7357;
  localparam logic signed [44:0]  C_P0      = 45'sd3791;
  localparam logic signed [24:0]  T_MAX     = 25'sd32767;
  localparam logic signed [24:0]  T_MIN     = -25'sd32768;
  localparam logic signed [41:0]  P_MAX     = 42'sd262143;

endpackage

FILE: hdl/baro_temp_pressure_compensate.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensate: barometric sensor integer compensation
// Turns raw temperature and pressure words into 0.1 degC and Pa using the
// calibration words held in the register file.
// ----------------------------------------------------------------------------
// Usage: a request (raw_temp, raw_pressure) is taken on any clock where start
// is high and busy is low; busy is high only during reset. Every request gives
// exactly one result on the result port, flagged by done for one cycle, in
// request order. One request per clock is sustained. The latency is set by
// the two pipelined dividers (temperature X2 and the pressure quotient),
// each producing DIV_BITS quotient bits per stage, plus thirteen arithmetic
// stages. The receiver cannot stall; results must be taken when done
// pulses. Calibration registers are written through cfg_we/cfg_index/cfg_data
// and must only be changed while no request is in flight. A zero divisor
// (X1+MD or B4) sets div_error and zeroes both readings; otherwise readings
// saturate.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensate #(
  parameter int DIV_BITS = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  baro_pkg::sample_t              sample,
  output logic                           done,
  output baro_pkg::result_t              result,
  input  logic                           cfg_we,
  input  logic [baro_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [baro_pkg::CFG_DATA_W-1:0] cfg_data
);

  import baro_pkg::*;

  localparam int T_DIV_STG = (27 + DIV_BITS - 1) / DIV_BITS;
  localparam int P_DIV_STG = (32 + DIV_BITS - 1) / DIV_BITS;
  localparam int LATENCY   = 13 + T_DIV_STG + P_DIV_STG;

  // --------------------------------------------------------------------------
  // Calibration register file
  // --------------------------------------------------------------------------
  logic [31:0] ac1_ac2, ac3_ac4, ac5_ac6, b1_b2, mc_md;
  logic [1:0]  oss;

  always_ff @(posedge clk) begin
    if (rst) begin
      ac1_ac2 <= '0;
      ac3_ac4 <= '0;
      ac5_ac6 <= '0;
      b1_b2   <= '0;
      mc_md   <= '0;
      oss     <= OSS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AC1_AC2: ac1_ac2 <= cfg_data;
        REG_AC3_AC4: ac3_ac4 <= cfg_data;
        REG_AC5_AC6: ac5_ac6 <= cfg_data;
        REG_B1_B2:   b1_b2   <= cfg_data;
        REG_MC_MD:   mc_md   <= cfg_data;
        REG_OSS:     oss     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic        [15:0] ac4, ac5, ac6;

  assign ac1 = ac1_ac2[31:16];
  assign ac2 = ac1_ac2[15:0];
  assign ac3 = ac3_ac4[31:16];
  assign ac4 = ac3_ac4[15:0];
  assign ac5 = ac5_ac6[31:16];
  assign ac6 = ac5_ac6[15:0];
  assign b1  = b1_b2[31:16];
  assign b2  = b1_b2[15:0];
  assign mc  = mc_md[31:16];
  assign md  = mc_md[15:0];

  // Requests are taken every cycle outside reset.
  assign busy = rst;

  // --------------------------------------------------------------------------
  // Stage 1: (UT - AC6) * AC5
  // --------------------------------------------------------------------------
  logic signed [16:0] ut_m_ac6;
  logic signed [33:0] prod_a;

  assign ut_m_ac6 = $signed({1'b0, sample.raw_temp}) - $signed({1'b0, ac6});
  assign prod_a   = ut_m_ac6 * $signed({1'b0, ac5});

  logic               s1_valid;
  logic signed [33:0] s1_prod;
  logic        [18:0] s1_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start & ~busy;
    end
    s1_prod <= prod_a;
    s1_up   <= sample.raw_pressure;
  end

  // --------------------------------------------------------------------------
  // Stage 2: X1, divisor X1+MD, operand magnitudes for the X2 divide
  // --------------------------------------------------------------------------
  logic signed [18:0] x1t;
  logic signed [19:0] den_t;
  logic        [19:0] den_abs;
  logic        [15:0] mc_abs;

  assign x1t     = s1_prod[33:15];
  assign den_t   = 20'(x1t) + 20'(md);
  assign den_abs = den_t[19] ? 20'(-den_t) : den_t;
  assign mc_abs  = mc[15] ? 16'(-mc) : mc;

  logic               s2_valid;
  logic        [26:0] s2_num;
  logic        [18:0] s2_den;
  logic               s2_neg;
  logic               s2_zero;
  logic signed [18:0] s2_x1;
  logic        [18:0] s2_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_num  <= {mc_abs, 11'd0};
    s2_den  <= den_abs[18:0];
    s2_neg  <= mc[15] ^ den_t[19];
    s2_zero <= (den_t == '0);
    s2_x1   <= x1t;
    s2_up   <= s1_up;
  end

  // --------------------------------------------------------------------------
  // X2 = MC*2048 / (X1+MD), truncating, on magnitudes
  // --------------------------------------------------------------------------
  logic        dt_valid;
  logic [26:0] dt_quot;
  logic [39:0] dt_side;

  baro_div #(
    .NUM_W (27),
    .DEN_W (19),
    .STEP  (DIV_BITS),
    .SIDE_W(40)
  ) u_div_t (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_valid),
    .in_num   (s2_num),
    .in_den   (s2_den),
    .in_side  ({s2_neg, s2_zero, s2_x1, s2_up}),
    .out_valid(dt_valid),
    .out_quot (dt_quot),
    .out_side (dt_side)
  );

  // --------------------------------------------------------------------------
  // Stage 3: B5, T (saturated), B6
  // --------------------------------------------------------------------------
  logic               dt_neg, dt_zero;
  logic signed [18:0] dt_x1;
  logic        [18:0] dt_up;
  logic signed [27:0] x2t;
  logic signed [28:0] b5, t_sum, b6_w;
  logic signed [24:0] t_raw;
  logic signed [15:0] t_sat;

  assign {dt_neg, dt_zero, dt_x1, dt_up} = dt_side;
  assign x2t   = dt_neg ? -$signed({1'b0, dt_quot}) : $signed({1'b0, dt_quot});
  assign b5    = 29'(dt_x1) + 29'(x2t);
  assign t_sum = b5 + T_ROUND;
  assign t_raw = t_sum[28:4];
  assign b6_w  = b5 - B6_OFFSET;

  always_comb begin
    if (t_raw > T_MAX) begin
      t_sat = T_MAX[15:0];
    end else if (t_raw < T_MIN) begin
      t_sat = T_MIN[15:0];
    end else begin
      t_sat = t_raw[15:0];
    end
  end

  logic               s3_valid, s3_zero;
  logic signed [15:0] s3_t;
  logic signed [27:0] s3_b6;
  logic        [18:0] s3_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= dt_valid;
    end
    s3_zero <= dt_zero;
    s3_t    <= t_sat;
    s3_b6   <= b6_w[27:0];   // |B6| < 2^27
    s3_up   <= dt_up;
  end

  // --------------------------------------------------------------------------
  // Stage 4: B6^2 >> 12, AC2*B6 >> 11, AC3*B6 >> 13
  // --------------------------------------------------------------------------
  logic signed [55:0] b6_sq;
  logic signed [43:0] ac2_b6, ac3_b6;

  assign b6_sq  = s3_b6 * s3_b6;
  assign ac2_b6 = ac2 * s3_b6;
  assign ac3_b6 = ac3 * s3_b6;

  logic               s4_valid, s4_zero;
  logic signed [15:0] s4_t;
  logic        [41:0] s4_sq;
  logic signed [32:0] s4_x2a;
  logic signed [30:0] s4_x1b;
  logic        [18:0] s4_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_zero <= s3_zero;
    s4_t    <= s3_t;
    s4_sq   <= b6_sq[53:12];
    s4_x2a  <= ac2_b6[43:11];
    s4_x1b  <= ac3_b6[43:13];
    s4_up   <= s3_up;
  end

  // --------------------------------------------------------------------------
  // Stage 5: B2*SQ and B1*SQ as two half products each
  // --------------------------------------------------------------------------
  logic signed [37:0] b2_hi, b2_lo, b1_hi, b1_lo;

  assign b2_hi = b2 * $signed({1'b0, s4_sq[41:21]});
  assign b2_lo = b2 * $signed({1'b0, s4_sq[20:0]});
  assign b1_hi = b1 * $signed({1'b0, s4_sq[41:21]});
  assign b1_lo = b1 * $signed({1'b0, s4_sq[20:0]});

  logic               s5_valid, s5_zero;
  logic signed [15:0] s5_t;
  logic signed [37:0] s5_b2_hi, s5_b2_lo, s5_b1_hi, s5_b1_lo;
  logic signed [32:0] s5_x2a;
  logic signed [30:0] s5_x1b;
  logic        [18:0] s5_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_zero  <= s4_zero;
    s5_t     <= s4_t;
    s5_b2_hi <= b2_hi;
    s5_b2_lo <= b2_lo;
    s5_b1_hi <= b1_hi;
    s5_b1_lo <= b1_lo;
    s5_x2a   <= s4_x2a;
    s5_x1b   <= s4_x1b;
    s5_up    <= s4_up;
  end

  // --------------------------------------------------------------------------
  // Stage 6: recombine halves, X1 for B3 (>>11) and X2 for B4 (>>16)
  // --------------------------------------------------------------------------
  logic signed [58:0] b2_sq, b1_sq;

  assign b2_sq = (59'(s5_b2_hi) <<< 21) + 59'(s5_b2_lo);
  assign b1_sq = (59'(s5_b1_hi) <<< 21) + 59'(s5_b1_lo);

  logic               s6_valid, s6_zero;
  logic signed [15:0] s6_t;
  logic signed [47:0] s6_x1a;
  logic signed [42:0] s6_x2b;
  logic signed [32:0] s6_x2a;
  logic signed [30:0] s6_x1b;
  logic        [18:0] s6_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= s5_valid;
    end
    s6_zero <= s5_zero;
    s6_t    <= s5_t;
    s6_x1a  <= b2_sq[58:11];
    s6_x2b  <= b1_sq[58:16];
    s6_x2a  <= s5_x2a;
    s6_x1b  <= s5_x1b;
    s6_up   <= s5_up;
  end

  // --------------------------------------------------------------------------
  // Stage 7: sums for B3 and X3; only bits below 2^34 matter downstream
  // --------------------------------------------------------------------------
  logic [33:0] sum_a, sum_b;

  assign sum_a = (34'(ac1) << 2) + s6_x1a[33:0] + 34'(s6_x2a);
  assign sum_b = s6_x2b[33:0] + 34'(s6_x1b) + 34'd2;

  logic               s7_valid, s7_zero;
  logic signed [15:0] s7_t;
  logic        [33:0] s7_sa, s7_sb;
  logic        [18:0] s7_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else begin
      s7_valid <= s6_valid;
    end
    s7_zero <= s6_zero;
    s7_t    <= s6_t;
    s7_sa   <= sum_a;
    s7_sb   <= sum_b;
    s7_up   <= s6_up;
  end

  // --------------------------------------------------------------------------
  // Stage 8: B3 mod 2^32 and the factor X3+32768 mod 2^32
  // --------------------------------------------------------------------------
  logic [33:0] b3_sum;

  assign b3_sum = (s7_sa << oss) + 34'd2;

  logic               s8_valid, s8_zero;
  logic signed [15:0] s8_t;
  logic        [31:0] s8_b3, s8_f;
  logic        [18:0] s8_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else begin
      s8_valid <= s7_valid;
    end
    s8_zero <= s7_zero;
    s8_t    <= s7_t;
    s8_b3   <= b3_sum[33:2];
    s8_f    <= s7_sb[33:2] + X3_BIAS;
    s8_up   <= s7_up;
  end

  // --------------------------------------------------------------------------
  // Stage 9: B4 and UP-B3, both modulo 2^32
  // --------------------------------------------------------------------------
  logic [47:0] b4_prod;

  assign b4_prod = ac4 * s8_f;

  logic               s9_valid, s9_zero;
  logic signed [15:0] s9_t;
  logic        [16:0] s9_b4;
  logic        [31:0] s9_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_valid <= 1'b0;
    end else begin
      s9_valid <= s8_valid;
    end
    s9_zero <= s8_zero;
    s9_t    <= s8_t;
    s9_b4   <= b4_prod[31:15];
    s9_diff <= {13'd0, s8_up} - s8_b3;
  end

  // --------------------------------------------------------------------------
  // Stage 10: B7 = (UP-B3) * (50000 >> OSS) mod 2^32, divisor check
  // --------------------------------------------------------------------------
  logic [15:0] b7_scale;
  logic [47:0] b7_prod;

  assign b7_scale = 16'(B7_SCALE >> oss);
  assign b7_prod  = s9_diff * b7_scale;

  logic               s10_valid, s10_zero;
  logic signed [15:0] s10_t;
  logic        [16:0] s10_b4;
  logic        [31:0] s10_b7;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_valid <= 1'b0;
    end else begin
      s10_valid <= s9_valid;
    end
    s10_zero <= s9_zero | (s9_b4 == '0);
    s10_t    <= s9_t;
    s10_b4   <= s9_b4;
    s10_b7   <= b7_prod[31:0];
  end

  // --------------------------------------------------------------------------
  // Pressure quotient: B7*2/B4 when B7 < 2^31, else (B7/B4)*2
  // --------------------------------------------------------------------------
  logic        b7_top;
  logic [31:0] p_num;

  assign b7_top = s10_b7[31];
  assign p_num  = b7_top ? s10_b7 : {s10_b7[30:0], 1'b0};

  logic        dp_valid;
  logic [31:0] dp_quot;
  logic [17:0] dp_side;

  baro_div #(
    .NUM_W (32),
    .DEN_W (17),
    .STEP  (DIV_BITS),
    .SIDE_W(18)
  ) u_div_p (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s10_valid),
    .in_num   (p_num),
    .in_den   (s10_b4),
    .in_side  ({b7_top, s10_zero, s10_t}),
    .out_valid(dp_valid),
    .out_quot (dp_quot),
    .out_side (dp_side)
  );

  // --------------------------------------------------------------------------
  // Stage 11: p as signed 32, (p>>8)^2 and -7357*p >> 16
  // --------------------------------------------------------------------------
  logic               dp_top, dp_zero;
  logic signed [15:0] dp_t;
  logic signed [31:0] p0;
  logic signed [23:0] p_sh8;
  logic signed [47:0] p_sq;
  logic signed [45:0] p_lin;

  assign {dp_top, dp_zero, dp_t} = dp_side;
  assign p0    = dp_top ? $signed({dp_quot[30:0], 1'b0}) : $signed(dp_quot);
  assign p_sh8 = p0[31:8];
  assign p_sq  = p_sh8 * p_sh8;
  assign p_lin = p0 * C_P1;

  logic               s11_valid, s11_zero;
  logic signed [15:0] s11_t;
  logic signed [31:0] s11_p;
  logic        [46:0] s11_sq;
  logic signed [29:0] s11_x2c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_valid <= 1'b0;
    end else begin
      s11_valid <= dp_valid;
    end
    s11_zero <= dp_zero;
    s11_t    <= dp_t;
    s11_p    <= p0;
    s11_sq   <= p_sq[46:0];   // non-negative, at most 2^46
    s11_x2c  <= p_lin[45:16];
  end

  // --------------------------------------------------------------------------
  // Stage 12: X1 = (sq * 3038) >> 16
  // --------------------------------------------------------------------------
  logic [58:0] x1c_prod;

  assign x1c_prod = s11_sq * C_P2;

  logic               s12_valid, s12_zero;
  logic signed [15:0] s12_t;
  logic signed [31:0] s12_p;
  logic        [42:0] s12_x1c;
  logic signed [29:0] s12_x2c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s12_valid <= 1'b0;
    end else begin
      s12_valid <= s11_valid;
    end
    s12_zero <= s11_zero;
    s12_t    <= s11_t;
    s12_p    <= s11_p;
    s12_x1c  <= x1c_prod[58:16];
    s12_x2c  <= s11_x2c;
  end

  // --------------------------------------------------------------------------
  // Stage 13: final correction, saturation, error override
  // --------------------------------------------------------------------------
  logic signed [44:0] corr_sum;
  logic signed [40:0] corr;
  logic signed [41:0] p_fin;
  logic        [17:0] p_sat;

  assign corr_sum = $signed({2'b00, s12_x1c}) + 45'(s12_x2c) + C_P0;
  assign corr     = corr_sum[44:4];
  assign p_fin    = 42'(s12_p) + 42'(corr);

  always_comb begin
    if (p_fin < 0) begin
      p_sat = '0;
    end else if (p_fin > P_MAX) begin
      p_sat = P_MAX[17:0];
    end else begin
      p_sat = p_fin[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s12_valid;
    end
    if (s12_zero) begin
      result.temp_tenths_c <= '0;
      result.pressure_pa   <= '0;
      result.div_error     <= 1'b1;
    end else begin
      result.temp_tenths_c <= s12_t;
      result.pressure_pa   <= p_sat;
      result.div_error     <= 1'b0;
    end
  end

endmodule

FILE: hdl/baro_div.sv
// ----------------------------------------------------------------------------
// baro_div: pipelined unsigned divider
// Restoring division, STEP quotient bits per register stage, one request
// per cycle, side data travels with each request.
// ----------------------------------------------------------------------------
module baro_div #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 17,
  parameter int STEP   = 2,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quot,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STAGES = (NUM_W + STEP - 1) / STEP;
  localparam int TOT_W  = STAGES * STEP;

  // numerator bits shift out the top while quotient bits shift in below
  logic              vld  [STAGES+1];
  logic [TOT_W-1:0]  nq   [STAGES+1];
  logic [DEN_W-1:0]  rem  [STAGES+1];
  logic [DEN_W-1:0]  dreg [STAGES+1];
  logic [SIDE_W-1:0] sreg [STAGES+1];

  assign vld[0]  = in_valid;
  assign nq[0]   = TOT_W'(in_num);
  assign rem[0]  = '0;
  assign dreg[0] = in_den;
  assign sreg[0] = in_side;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [TOT_W-1:0] nq_next;
    logic [DEN_W-1:0] rem_next;

    always_comb begin
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           qb;
      nq_next  = nq[s];
      rem_next = rem[s];
      for (int k = 0; k < STEP; k++) begin
        trial = {rem_next, nq_next[TOT_W-1]};
        diff  = trial - {1'b0, dreg[s]};
        qb    = (trial >= {1'b0, dreg[s]});
        rem_next = qb ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_next  = {nq_next[TOT_W-2:0], qb};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      nq[s+1]   <= nq_next;
      rem[s+1]  <= rem_next;
      dreg[s+1] <= dreg[s];
      sreg[s+1] <= sreg[s];
    end
  end

  assign out_valid = vld[STAGES];
  assign out_quot  = nq[STAGES][NUM_W-1:0];
  assign out_side  = sreg[STAGES];

endmodule

FILE: hdl/baro_checker.sv
// ----------------------------------------------------------------------------
// baro_checker: port-level checks for the compensation block
// Fixed request-to-result latency, reset behavior and error reporting.
// ----------------------------------------------------------------------------
module baro_checker #(
  parameter int LATENCY = 43
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input baro_pkg::result_t result
);

  import baro_pkg::*;

  // busy only while reset is applied
  a_busy_rst: assert property (@(posedge clk) busy == rst)
    else $error("busy does not track reset");

  // pipeline is empty right after reset
  a_quiet_after_rst: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result after reset");

  // every result comes from an earlier accepted request
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching request");

  // divide error forces zero readings
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.div_error) |->
      (result.temp_tenths_c == '0 && result.pressure_pa == '0))
    else $error("nonzero readings with div_error");

endmodule

bind baro_temp_pressure_compensate baro_checker #(.LATENCY(LATENCY)) u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);

FILE: verif/baro_checker.sv
// ----------------------------------------------------------------------------
// baro_scoreboard: result predictor and scoreboard for the compensation block
// Watches the request, result and register-write ports, computes the expected
// reading for every accepted request and compares results in order.
// ----------------------------------------------------------------------------
module baro_scoreboard (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  baro_pkg::sample_t               sample,
  input  logic                            done,
  input  baro_pkg::result_t               result,
  input  logic                            cfg_we,
  input  logic [baro_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [baro_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              errors,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import baro_pkg::*;

  logic [31:0] cal [0:4];
  logic [1:0]  oss;
  result_t     expected_q [$];

  function automatic longint sx16(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  // Floor shift; >>> on longint already rounds toward minus infinity.
  function automatic longint fsr(longint x, int n);
    return x >>> n;
  endfunction

  function automatic result_t compensate(sample_t s);
    result_t r;
    longint ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut, up;
    longint x1, x2, x3, b3, b5, b6, t, den, sq, p;
    longint unsigned ac4, b4, b7, q;
    ac1 = sx16(cal[0][31:16]); ac2 = sx16(cal[0][15:0]);
    ac3 = sx16(cal[1][31:16]); ac4 = cal[1][15:0];
    ac5 = cal[2][31:16];       ac6 = cal[2][15:0];
    b1  = sx16(cal[3][31:16]); b2  = sx16(cal[3][15:0]);
    mc  = sx16(cal[4][31:16]); md  = sx16(cal[4][15:0]);
    ut = s.raw_temp; up = s.raw_pressure;
    r = '0; r.div_error = 1'b1;
    x1 = fsr((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return r;
    x2 = (mc * 2048) / den;
    b5 = x1 + x2;
    t = fsr(b5 + 8, 4);
    b6 = b5 - 4000;
    sq = fsr(b6 * b6, 12);
    x3 = fsr(b2 * sq, 11) + fsr(ac2 * b6, 11);
    b3 = fsr((ac1 * 4 + x3) * (longint'(1) << oss) + 2, 2);
    x3 = fsr(fsr(ac3 * b6, 13) + fsr(b1 * sq, 16) + 2, 2);
    b4 = ((ac4 * (longint'(x3 + 32768) & 64'hFFFF_FFFF)) & 64'hFFFF_FFFF) >> 15;
    if (b4 == 0) return r;
    b7 = ((longint'(up - b3) & 64'hFFFF_FFFF) * (64'd50000 >> oss)) & 64'hFFFF_FFFF;
    if (b7 < 64'h8000_0000) q = (b7 * 2) / b4;
    else q = ((b7 / b4) * 2) & 64'hFFFF_FFFF;
    p = longint'(signed'(q[31:0]));
    x1 = fsr(p, 8) * fsr(p, 8);
    x1 = fsr(x1 * 3038, 16);
    x2 = fsr(-7357 * p, 16);
    p = p + fsr(x1 + x2 + 3791, 4);
    r.div_error = 1'b0;
    r.temp_tenths_c = (t < -32768) ? -16'sd32768 : (t > 32767) ? 16'sd32767 : t[15:0];
    r.pressure_pa = (p < 0) ? 18'd0 : (p > 262143) ? 18'h3FFFF : p[17:0];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  assign pending = expected_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      for (int i = 0; i < 5; i++) cal[i] <= '0;
      oss <= OSS_RESET;
      expected_q.delete();
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", result, 0);
        end else begin
          e = expected_q.pop_front();
          if (result.temp_tenths_c !== e.temp_tenths_c)
            report("temp_tenths_c", result.temp_tenths_c, e.temp_tenths_c);
          if (result.pressure_pa !== e.pressure_pa)
            report("pressure_pa", result.pressure_pa, e.pressure_pa);
          if (result.div_error !== e.div_error)
            report("div_error", result.div_error, e.div_error);
        end
      end
      // request uses the registers as they stand before this edge
      if (start && !busy) expected_q.push_back(compensate(sample));
      if (cfg_we) begin
        if (cfg_index == REG_OSS) oss <= cfg_data[1:0];
        else if (cfg_index < REG_OSS) cal[cfg_index] <= cfg_data;
      end
    end
  end
endmodule

FILE: verif/tb_baro_temp_pressure_compensate.sv
// ----------------------------------------------------------------------------
// tb_baro_temp_pressure_compensate: stimulus and verdict
// Loads several calibration sets (typical datasheet values, zeros, extremes,
// random), drives directed and bursty random requests, and lets the checker
// score every result.
// ----------------------------------------------------------------------------
module tb_baro_temp_pressure_compensate;
  timeunit 1ns;
  timeprecision 1ps;
  import baro_pkg::*;

  localparam int LATENCY   = 43;
  localparam int CYCLE_MAX = 400000;

  logic clk, rst, start, busy, done, cfg_we;
  sample_t sample;
  result_t result;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int errors, pending, cycles;

  baro_temp_pressure_compensate DUT (.*);

  baro_scoreboard checker_i (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Watchdog: counts every cycle of the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_cal(logic [31:0] c0, c1, c2, c3, c4, logic [1:0] o);
    write_reg(REG_AC1_AC2, c0);
    write_reg(REG_AC3_AC4, c1);
    write_reg(REG_AC5_AC6, c2);
    write_reg(REG_B1_B2, c3);
    write_reg(REG_MC_MD, c4);
    write_reg(REG_OSS, {30'd0, o});
  endtask

  // Holds start until the request is taken; start stays high across
  // back-to-back requests, only the payload changes.
  task automatic send(logic [15:0] ut, logic [18:0] up, bit keep);
    start = 1'b1;
    sample.raw_temp = ut; sample.raw_pressure = up;
    do @(negedge clk); while (busy);
    if (!keep) start = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // Random bursts; mostly realistic readings, some full-range noise.
  task automatic random_phase(int n);
    int burst;
    bit real_ish;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && n > 0; i++, n--) begin
        real_ish = $urandom_range(0, 3) != 0;
        send(real_ish ? 16'($urandom_range(22000, 34000)) : 16'($urandom),
             real_ish ? 19'($urandom_range(20000, 200000)) : 19'($urandom),
             (i + 1 < burst) && (n > 1));
      end
      start = 1'b0;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    sample = '0; cycles = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // reset registers: temperature divisor is zero, every result flagged
    send(16'd0, 19'd0, 1);
    send(16'hFFFF, 19'h7FFFF, 0);
    drain();

    // datasheet example calibration
    load_cal({16'd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
             {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'd0);
    send(16'd27898, 19'd23843, 1);
    send(16'd0, 19'd0, 1);
    send(16'hFFFF, 19'h7FFFF, 1);
    send(16'hFFFF, 19'd0, 1);
    send(16'd0, 19'h7FFFF, 1);
    send(16'h5555, 19'h2AAAA, 1);
    send(16'hAAAA, 19'h55555, 0);
    drain();

    // AC4 zero: pressure divisor zero
    write_reg(REG_AC3_AC4, 32'h0000_0000);
    send(16'd27898, 19'd23843, 0);
    drain();

    // AC5 zero and MD zero: X1+MD zero
    load_cal(32'h0198_FFB8, 32'hC7D1_7FE5, 32'h0000_5A71, 32'h182E_0004,
             32'hDDE9_0000, 2'd3);
    send(16'd1234, 19'd40000, 0);
    drain();

    // extreme coefficients at each oversampling setting
    for (int o = 0; o < 4; o++) begin
      load_cal(o[0] ? 32'h7FFF_8000 : 32'h8000_7FFF, o[1] ? 32'h7FFF_FFFF : 32'h8000_0001,
               o[0] ? 32'hFFFF_FFFF : 32'h0001_0000, o[1] ? 32'h7FFF_8000 : 32'h8000_7FFF,
               o[0] ? 32'h7FFF_0001 : 32'h8000_7FFF, 2'(o));
      send(16'd0, 19'h7FFFF, 1);
      send(16'hFFFF, 19'd0, 1);
      send(16'd30000, 19'd100000, 0);
      drain();
    end

    // random phases: realistic calibration mostly, fully random sometimes
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 3 == 2)
        load_cal($urandom, $urandom, $urandom, $urandom, $urandom, 2'($urandom));
      else
        load_cal({16'($urandom_range(100, 9000)), 16'(-$urandom_range(0, 1200))},
                 {16'(-$urandom_range(5000, 16000)), 16'($urandom_range(28000, 40000))},
                 {16'($urandom_range(20000, 40000)), 16'($urandom_range(15000, 30000))},
                 {16'($urandom_range(4000, 8000)), 16'($urandom_range(0, 60))},
                 {16'(-$urandom_range(6000, 12000)), 16'($urandom_range(1500, 4000))},
                 2'($urandom));
      random_phase(150);
      drain();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
